// ----- design/nrat_pkg.sv -----
// ----------------------------------------------------------------------------
// nrat_pkg
// Shared types and constants for the nearest reference altitude table.
// ----------------------------------------------------------------------------
package nrat_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] ground_height;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] height_out;
    logic [7:0]         match_index;
    logic [1:0]         status;
  } out_word_t;

  // word handed from front end to back end
  typedef struct packed {
    cmd_t               cmd;
    status_t            status;
    logic [IdxW-1:0]    slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] height;
  } job_t;

endpackage

// ----- design/nrat_front.sv -----
// ----------------------------------------------------------------------------
// nrat_front
// Accepts commands, tracks the entry count and classifies each word into
// a job for the back end.
// ----------------------------------------------------------------------------
module nrat_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  nrat_pkg::in_word_t   in_word,
  output nrat_pkg::job_t       job
);

  logic [nrat_pkg::CntW-1:0] count_r, count_nxt;
  nrat_pkg::cmd_t            cmd;

  assign cmd   = nrat_pkg::cmd_t'(in_word.command);

  always_comb begin
    count_nxt    = count_r;
    job.cmd      = cmd;
    job.status   = nrat_pkg::ST_OK;
    job.slot     = count_r[nrat_pkg::IdxW-1:0];
    job.pos_x    = in_word.pos_x;
    job.pos_y    = in_word.pos_y;
    job.pos_z    = in_word.pos_z;
    job.height   = in_word.ground_height;
    unique case (cmd)
      nrat_pkg::CMD_CLEAR: count_nxt = '0;
      nrat_pkg::CMD_ADD: begin
        if (count_r == nrat_pkg::CntW'(nrat_pkg::TableDepth)) begin
          job.status = nrat_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      nrat_pkg::CMD_QUERY: begin
        if (count_r == '0) job.status = nrat_pkg::ST_EMPTY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/nrat_queue.sv -----
// ----------------------------------------------------------------------------
// nrat_queue
// Small FIFO of jobs between front and back end.
// ----------------------------------------------------------------------------
module nrat_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrat_pkg::job_t push_job,
  input  logic           pop,
  output nrat_pkg::job_t head,
  output logic           not_empty,
  output logic           full
);

  nrat_pkg::job_t              slot_r [nrat_pkg::QueueDepth];
  logic [nrat_pkg::QPtrW-1:0]  wr_r, rd_r;
  logic [nrat_pkg::QPtrW:0]    fill_r;

  assign head      = slot_r[rd_r];
  assign not_empty = fill_r != '0;
  assign full      = fill_r == (nrat_pkg::QPtrW+1)'(nrat_pkg::QueueDepth);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      fill_r <= fill_r + (nrat_pkg::QPtrW+1)'(push) - (nrat_pkg::QPtrW+1)'(pop);
    end
  end

endmodule

// ----- design/nrat_norm.sv -----
// ----------------------------------------------------------------------------
// nrat_norm
// Iterative normalizer: squares and sums the three magnitudes, integer square
// root two bits a cycle, then three restoring divides one bit a cycle.
// ----------------------------------------------------------------------------
module nrat_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  output logic               done,
  output logic signed [17:0] ux,
  output logic signed [17:0] uy,
  output logic signed [17:0] uz
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_DIV, S_DONE} state_t;

  state_t       state_r;
  logic [31:0]  mag_r [3];
  logic         neg_r [3];
  logic [65:0]  sum_r;
  logic [1:0]   k_r;
  logic [5:0]   it_r;
  logic [65:0]  rem_r;
  logic [32:0]  root_r;
  logic [47:0]  num_r;
  logic [33:0]  dr_r;
  logic [16:0]  q_r [3];
  logic [63:0]  sq;
  logic [65:0]  trial;
  logic [1:0]   pair;
  logic [34:0]  dtrial;
  logic [16:0]  qfin;

  assign sq     = mag_r[k_r] * mag_r[k_r];
  assign pair   = sum_r[65:64];
  assign trial  = {rem_r[63:0], pair} - {31'd0, root_r, 2'b01};
  assign dtrial = {dr_r, num_r[47]} - {2'b00, root_r};
  assign qfin   = q_r[k_r];

  function automatic logic signed [17:0] sgn(input logic [16:0] q, input logic n);
    logic signed [17:0] v;
    v = $signed({1'b0, q});
    return n ? -v : v;
  endfunction

  assign done = state_r == S_DONE;
  assign ux   = (root_r == '0) ? '0 : sgn(q_r[0], neg_r[0]);
  assign uy   = (root_r == '0) ? '0 : sgn(q_r[1], neg_r[1]);
  assign uz   = (root_r == '0) ? '0 : sgn(q_r[2], neg_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (go) begin
          mag_r[0] <= vx[31] ? 32'(-vx) : vx;
          mag_r[1] <= vy[31] ? 32'(-vy) : vy;
          mag_r[2] <= vz[31] ? 32'(-vz) : vz;
          neg_r[0] <= vx[31];
          neg_r[1] <= vy[31];
          neg_r[2] <= vz[31];
          sum_r    <= '0;
          k_r      <= '0;
          state_r  <= S_SQ;
        end
        S_SQ: begin
          sum_r <= sum_r + 66'(sq);
          if (k_r == 2'd2) begin
            state_r <= S_SQRT;
            it_r    <= '0;
            rem_r   <= '0;
            root_r  <= '0;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_SQRT: begin
          // 33 digit pairs of the 66-bit sum, msb first
          sum_r <= {sum_r[63:0], 2'b00};
          if (!trial[65]) begin
            rem_r  <= trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= {rem_r[63:0], pair};
            root_r <= {root_r[31:0], 1'b0};
          end
          if (it_r == 6'd32) begin
            state_r <= S_DIV;
            k_r     <= '0;
            it_r    <= '0;
            num_r   <= {mag_r[0], 16'd0};
            dr_r    <= '0;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        S_DIV: begin
          // quotient never exceeds 2^16, so 17 low bits suffice
          num_r <= {num_r[46:0], 1'b0};
          if (!dtrial[34]) begin
            dr_r      <= dtrial[33:0];
            q_r[k_r]  <= {qfin[15:0], 1'b1};
          end else begin
            dr_r      <= {dr_r[32:0], num_r[47]};
            q_r[k_r]  <= {qfin[15:0], 1'b0};
          end
          if (it_r == 6'd47) begin
            it_r <= '0;
            dr_r <= '0;
            if (k_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              k_r   <= k_r + 1'b1;
              num_r <= {mag_r[k_r + 1'b1], 16'd0};
            end
          end else begin
            it_r <= it_r + 1'b1;
          end
          if (it_r == 6'd0) q_r[k_r] <= {16'd0, !dtrial[34]};
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/nrat_back.sv -----
// ----------------------------------------------------------------------------
// nrat_back
// Carries out jobs: writes normalized entries, scans the table for queries
// entry by entry, finishing each before reading the next, and emits one result word per job.
// ----------------------------------------------------------------------------
module nrat_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  input  nrat_pkg::job_t            job,
  input  logic [nrat_pkg::CntW-1:0] count,
  output logic                      job_pop,
  output logic                      out_strobe,
  output nrat_pkg::out_word_t       out_word
);

  typedef enum logic [2:0] {B_IDLE, B_NORM, B_SCAN, B_MUL, B_SUM, B_FIN} state_t;

  state_t                      state_r;
  nrat_pkg::job_t              job_r;
  logic [nrat_pkg::CntW-1:0]   n_r;
  logic [nrat_pkg::CntW-1:0]   rd_r;
  logic [nrat_pkg::IdxW-1:0]   cur_r;
  logic                        pend_r;
  logic signed [53:0]  unit_mem [nrat_pkg::TableDepth];
  logic signed [31:0]  hgt_mem  [nrat_pkg::TableDepth];
  logic signed [53:0]  ud_r;
  logic signed [31:0]  hd_r;
  logic signed [49:0]  px_r, py_r, pz_r;
  logic signed [51:0]  dot;
  logic signed [51:0]  best_r;
  logic [nrat_pkg::IdxW-1:0]   best_i_r;
  logic                first_r;
  logic                ngo;
  logic                ndone;
  logic signed [17:0]  ux, uy, uz;

  nrat_norm u_norm (
    .clk(clk), .rst_n(rst_n), .go(ngo),
    .vx(job_r.pos_x), .vy(job_r.pos_y), .vz(job_r.pos_z),
    .done(ndone), .ux(ux), .uy(uy), .uz(uz)
  );

  assign ngo     = state_r == B_NORM && !pend_r;
  assign job_pop = state_r == B_IDLE && job_valid;
  assign dot     = 52'(px_r) + 52'(py_r) + 52'(pz_r);

  always_ff @(posedge clk) begin
    if (state_r == B_NORM && ndone) begin
      unit_mem[job_r.slot] <= {ux, uy, uz};
      hgt_mem[job_r.slot]  <= job_r.height;
    end
    ud_r <= unit_mem[rd_r[nrat_pkg::IdxW-1:0]];
    hd_r <= hgt_mem[best_i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      out_strobe <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        B_IDLE: if (job_valid) begin
          job_r   <= job;
          n_r     <= count;
          pend_r  <= 1'b0;
          rd_r    <= '0;
          first_r <= 1'b1;
          best_i_r <= '0;
          if (job.cmd == nrat_pkg::CMD_ADD && job.status == nrat_pkg::ST_OK) begin
            state_r <= B_NORM;
          end else if (job.cmd == nrat_pkg::CMD_QUERY
                       && job.status == nrat_pkg::ST_OK) begin
            state_r <= B_SCAN;
          end else begin
            out_word.height_out  <= '0;
            out_word.match_index <= '0;
            out_word.status      <= job.status;
            out_strobe           <= 1'b1;
          end
        end
        B_NORM: begin
          pend_r <= 1'b1;
          if (ndone) begin
            out_word   <= '0;
            out_strobe <= 1'b1;
            state_r    <= B_IDLE;
          end
        end
        B_SCAN: begin
          // memory read of entry rd_r lands in ud_r next cycle
          cur_r   <= rd_r[nrat_pkg::IdxW-1:0];
          rd_r    <= rd_r + 1'b1;
          state_r <= B_MUL;
        end
        B_MUL: begin
          px_r    <= job_r.pos_x * $signed(ud_r[53:36]);
          py_r    <= job_r.pos_y * $signed(ud_r[35:18]);
          pz_r    <= job_r.pos_z * $signed(ud_r[17:0]);
          state_r <= B_SUM;
        end
        B_SUM: begin
          if (first_r || dot > best_r) begin
            best_r   <= dot;
            best_i_r <= cur_r;
          end
          first_r <= 1'b0;
          state_r <= (rd_r == n_r) ? B_FIN : B_SCAN;
        end
        B_FIN: begin
          if (pend_r) begin
            out_word.height_out  <= hd_r;
            out_word.match_index <= 8'(best_i_r);
            out_word.status      <= nrat_pkg::ST_OK;
            out_strobe           <= 1'b1;
            state_r              <= B_IDLE;
          end
          pend_r <= 1'b1;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/nearest_reference_altitude_table_core.sv -----
// ----------------------------------------------------------------------------
// nearest_reference_altitude_table_core
// Table of unit reference directions with altitudes; answers nearest-angle
// queries.
//
//   channel | ports                           | handshake
//   input   | in_word, start, busy            | start && !busy
//   result  | out_word, out_strobe            | one cycle, no stall
//
// Clear and full/empty/nop words are answered straight from the idle state.
// Add time is set by the bit-serial square root and three dividers.
// Query scans the stored entries one at a time (one table read port).
// Reset synchronous, active low; table contents undefined until written.
// busy is high while the job queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
module nearest_reference_altitude_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nrat_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output nrat_pkg::out_word_t out_word
);

  logic                      acc;
  nrat_pkg::job_t            fjob;
  nrat_pkg::job_t            head;
  logic                      q_ne, q_full, pop;

  assign busy = q_full;
  assign acc  = start && !busy;

  nrat_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .in_word(in_word),
    .job(fjob)
  );

  nrat_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(acc), .push_job(fjob),
    .pop(pop), .head(head), .not_empty(q_ne), .full(q_full)
  );

  // a query's slot holds the entry count at accept time; zero there means
  // a full table, since an empty one is never scanned
  nrat_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job(head),
    .count((head.slot == '0) ? nrat_pkg::CntW'(nrat_pkg::TableDepth)
                             : {1'b0, head.slot}),
    .job_pop(pop), .out_strobe(out_strobe), .out_word(out_word)
  );

endmodule

// ----- tb/tb_nearest_reference_altitude_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_reference_altitude_table_core
// Drives clear/add/query/nop words with random gaps, predicts each result
// with an in-bench altitude table model and checks the words in order.
// ----------------------------------------------------------------------------
module tb_nearest_reference_altitude_table_core;

  localparam int WatchdogLimit = 20000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  nrat_pkg::in_word_t  in_word;
  logic                out_strobe;
  nrat_pkg::out_word_t out_word;

  nearest_reference_altitude_table_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // predictor state
  logic signed [17:0] tbl_ux [nrat_pkg::TableDepth];
  logic signed [17:0] tbl_uy [nrat_pkg::TableDepth];
  logic signed [17:0] tbl_uz [nrat_pkg::TableDepth];
  logic signed [31:0] tbl_alt [nrat_pkg::TableDepth];
  int unsigned        tbl_count;

  nrat_pkg::in_word_t  pending_words[$];
  nrat_pkg::out_word_t expected_answers[$];
  int        fail_cnt;
  int        idle_cycles;
  int        gap_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] scale_axis(logic signed [31:0] c,
                                                     logic [63:0] m);
    logic [63:0] a;
    logic [63:0] q;
    a = c < 0 ? 64'(-64'(c)) : 64'(c);
    q = (a << 16) / m;
    return c < 0 ? -18'(q) : 18'(q);
  endfunction

  // applies one word to the model table and returns the answer word
  function automatic nrat_pkg::out_word_t altitude_table_step(nrat_pkg::in_word_t w);
    nrat_pkg::out_word_t r;
    logic [63:0] ax, ay, az, m;
    longint signed d, best_dot;
    int best;
    r = '0;
    case (nrat_pkg::cmd_t'(w.command))
      nrat_pkg::CMD_CLEAR: tbl_count = 0;
      nrat_pkg::CMD_ADD: begin
        if (tbl_count >= nrat_pkg::TableDepth) begin
          r.status = nrat_pkg::ST_FULL;
        end else begin
          ax = w.pos_x < 0 ? 64'(-64'(w.pos_x)) : 64'(w.pos_x);
          ay = w.pos_y < 0 ? 64'(-64'(w.pos_y)) : 64'(w.pos_y);
          az = w.pos_z < 0 ? 64'(-64'(w.pos_z)) : 64'(w.pos_z);
          m = root_floor(ax * ax + ay * ay + az * az);
          if (m == 0) begin
            tbl_ux[tbl_count] = 0;
            tbl_uy[tbl_count] = 0;
            tbl_uz[tbl_count] = 0;
          end else begin
            tbl_ux[tbl_count] = scale_axis(w.pos_x, m);
            tbl_uy[tbl_count] = scale_axis(w.pos_y, m);
            tbl_uz[tbl_count] = scale_axis(w.pos_z, m);
          end
          tbl_alt[tbl_count] = w.ground_height;
          tbl_count++;
        end
      end
      nrat_pkg::CMD_QUERY: begin
        if (tbl_count == 0) begin
          r.status = nrat_pkg::ST_EMPTY;
        end else begin
          best = 0;
          best_dot = 0;
          for (int i = 0; i < tbl_count; i++) begin
            d = longint'(w.pos_x) * longint'(tbl_ux[i])
              + longint'(w.pos_y) * longint'(tbl_uy[i])
              + longint'(w.pos_z) * longint'(tbl_uz[i]);
            if (i == 0 || d > best_dot) begin
              best_dot = d;
              best = i;
            end
          end
          r.height_out = tbl_alt[best];
          r.match_index = 8'(best);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 20)) - 10);
      3: return $signed($urandom_range(0, 8000000)) - 32'sd4000000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic nrat_pkg::in_word_t make_word(nrat_pkg::cmd_t c);
    nrat_pkg::in_word_t w;
    w.command = c;
    w.pos_x = rand_coord();
    w.pos_y = rand_coord();
    w.pos_z = rand_coord();
    w.ground_height = $signed($urandom());
    return w;
  endfunction

  function automatic nrat_pkg::in_word_t fixed_word(nrat_pkg::cmd_t c, int x, int y,
                                                    int z, int h);
    nrat_pkg::in_word_t w;
    w.command = c;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.ground_height = h;
    return w;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the word until taken
    end else begin
      if (start) begin
        expected_answers.push_back(altitude_table_step(in_word));
      end
      if (gap_left > 0 || pending_words.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        start <= 1'b1;
        in_word <= pending_words.pop_front();
        gap_left <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected word height=%0d idx=%0d st=%0d", $time,
                 out_word.height_out, out_word.match_index, out_word.status);
        fail_cnt++;
      end else begin
        nrat_pkg::out_word_t e;
        e = expected_answers.pop_front();
        if (e.height_out !== out_word.height_out)
          $display("%0t: height_out exp %0d act %0d", $time, e.height_out,
                   out_word.height_out);
        if (e.match_index !== out_word.match_index)
          $display("%0t: match_index exp %0d act %0d", $time, e.match_index,
                   out_word.match_index);
        if (e.status !== out_word.status)
          $display("%0t: status exp %0d act %0d", $time, e.status,
                   out_word.status);
        if (e !== out_word) fail_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[nearest_reference_altitude_table_core] ERROR");
      $finish;
    end
  end

  initial begin
    int n, k, r;
    nrat_pkg::cmd_t c;
    fail_cnt = 0;
    tbl_count = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;

    // directed: empty query, zero vector, axes, extremes, ties, nop, clear
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 1, 2, 3, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_NOP, -1, -1, -1, -1));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 0, 0, 0, 32'sh12345678));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 5, 5, 5, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 32'sh7FFFFFFF, 0, 0, 100));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 32'sh80000000, 0, 0, -100));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 0, 32'sh7FFFFFFF, 0,
                                       32'sh7FFFFFFF));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 0, 0, 32'sh80000000,
                                       32'sh80000000));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 32'sh80000000, 32'sh80000000,
                                       32'sh80000000, 7));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                       32'sh7FFFFFFF, 8));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_ADD, 3, 0, 0, 9));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 1000, 1, 0, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, -1000, 0, 0, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 0, 0, 0, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 32'sh80000000,
                                       32'sh80000000, 32'sh80000000, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 32'sh7FFFFFFF,
                                       32'sh7FFFFFFF, 32'sh7FFFFFFF, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_CLEAR, 0, 0, 0, 0));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_QUERY, 1, 1, 1, 0));
    // fill the table to check the full flag, then a query over every entry
    for (int i = 0; i < nrat_pkg::TableDepth + 2; i++)
      pending_words.push_back(make_word(nrat_pkg::CMD_ADD));
    pending_words.push_back(make_word(nrat_pkg::CMD_QUERY));
    pending_words.push_back(make_word(nrat_pkg::CMD_QUERY));
    pending_words.push_back(fixed_word(nrat_pkg::CMD_CLEAR, 0, 0, 0, 0));

    // random: short bursts mixing adds, queries, nops and clears
    n = 0;
    while (n < 270) begin
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) c = nrat_pkg::CMD_ADD;
        else if (r < 90) c = nrat_pkg::CMD_QUERY;
        else if (r < 95) c = nrat_pkg::CMD_NOP;
        else c = nrat_pkg::CMD_CLEAR;
        pending_words.push_back(make_word(c));
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[nearest_reference_altitude_table_core] OK");
    end else begin
      $display("[nearest_reference_altitude_table_core] ERROR");
    end
    $finish;
  end

endmodule
